// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros shared by the rpm block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked property, disabled while reset is high
`define WCRPM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wcrpm assertion failed");

// checked property, also checked during reset
`define WCRPM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("wcrpm assertion failed");

`else

`define WCRPM_ASSERT(label, clk, rst, prop)

`define WCRPM_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== design/wcrpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wcrpm_pkg
// types, constants and helpers for the wheel and crank rpm block
// ----------------------------------------------------------------------------
package wcrpm_pkg;

   localparam int WORD_W         = 16;
   localparam int MODE_W         = 2;
   localparam int RPM_W          = 40;
   localparam int FRACTION_BITS  = 8;
   localparam int PROD_W         = 32;
   localparam int NUM_W          = PROD_W + FRACTION_BITS;
   localparam int DIV_STEPS      = (NUM_W + 1) / 2;
   localparam int PAD_W          = 2 * DIV_STEPS;
   localparam int CNT_W          = $clog2(DIV_STEPS + 1);

   localparam logic [PROD_W-1:0] TICKS_PER_MINUTE = PROD_W'(61440);
   localparam logic [RPM_W-1:0]  RPM_MAX          = {RPM_W{1'b1}};

   typedef enum logic [MODE_W-1:0] {
      MODE_COMBINED = 2'd0,
      MODE_CADENCE  = 2'd1,
      MODE_SPEED    = 2'd2
   } sensor_mode_type;

   typedef enum logic {
      KIND_CADENCE = 1'b0,
      KIND_SPEED   = 1'b1
   } value_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SELECT,
      ST_START,
      ST_WAIT,
      ST_WRITE
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic req_ready;
      logic div_start;
      logic out_load;
   } seq_ctrl_type;

   function automatic logic [RPM_W-1:0] sat_rpm(input logic [PAD_W-1:0] quo);
      logic [63:0] wide;
      wide = 64'(quo);
      if (wide > 64'(RPM_MAX)) begin
         return RPM_MAX;
      end
      return wide[RPM_W-1:0];
   endfunction

endpackage

// ===== design/wcrpm_ifs.sv =====
// ----------------------------------------------------------------------------
// wcrpm_ifs
// valid/ready channels for sensor broadcast items and rpm result items
// ----------------------------------------------------------------------------
interface wcrpm_req_if;
   logic                         valid;
   logic                         ready;
   logic [wcrpm_pkg::WORD_W-1:0] word_at_1;
   logic [wcrpm_pkg::WORD_W-1:0] word_at_3;
   logic [wcrpm_pkg::WORD_W-1:0] word_at_5;
   logic [wcrpm_pkg::WORD_W-1:0] word_at_7;

   modport source (output valid, word_at_1, word_at_3, word_at_5, word_at_7,
                   input ready);
   modport sink   (input valid, word_at_1, word_at_3, word_at_5, word_at_7,
                   output ready);
endinterface

interface wcrpm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        value_kind;
   logic [wcrpm_pkg::RPM_W-1:0] rpm_fixed;
   logic                        last;

   modport source (output valid, value_kind, rpm_fixed, last, input ready);
   modport sink   (input valid, value_kind, rpm_fixed, last, output ready);
endinterface

// ===== design/wcrpm_div.sv =====
// ----------------------------------------------------------------------------
// wcrpm_div
// shared restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wcrpm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wcrpm_pkg::NUM_W-1:0]   dividend,
   input  logic [wcrpm_pkg::WORD_W-1:0]  divisor,
   output logic [wcrpm_pkg::PAD_W-1:0]   quotient,
   output wcrpm_pkg::div_status_type     status
);
   import wcrpm_pkg::*;

   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [PAD_W-1:0]  quo_ff, quo_in;
   logic [WORD_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [WORD_W-1:0] step_rem;
   logic [PAD_W-1:0]  step_quo;
   logic [WORD_W:0]   trial;

   // two dependent shift-subtract steps
   always_comb begin
      step_rem = rem_ff;
      step_quo = quo_ff;
      trial    = '0;
      for (int i = 0; i < 2; i++) begin
         trial    = {step_rem, step_quo[PAD_W-1]};
         step_quo = {step_quo[PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            step_rem    = WORD_W'(trial - {1'b0, dsr_ff});
            step_quo[0] = 1'b1;
         end else begin
            step_rem = trial[WORD_W-1:0];
         end
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = PAD_W'(dividend);
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = step_rem;
         quo_in = step_quo;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `WCRPM_ASSERT(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff) && !busy_ff)
   `WCRPM_ASSERT(a_start_sets_busy, clock, reset, start |=> busy_ff)

endmodule

// ===== design/wheel_and_crank_rpm_from_events_core.sv =====
// ----------------------------------------------------------------------------
// wheel_and_crank_rpm_from_events_core
// rpm from sensor event times and revolution counts
// ----------------------------------------------------------------------------
// Each accepted item is one sensor broadcast. The first broadcast after reset
// gives no result; later ones give up to two results (cadence then wheel speed
// in combined mode), each only when its event time moved. Every result runs
// through one shared divider that retires two quotient bits a cycle. Each
// measurement passes the select, start, wait and write states in that order,
// and a stalled result channel holds it in the write state. The block takes
// no new item until its last result is loaded into the output register; a
// finished result may wait there while the next item is taken. No clearing
// pass follows reset.
`include "assert_macros.svh"

module wheel_and_crank_rpm_from_events_core (
   input  logic                          clock,
   input  logic                          reset,
   wcrpm_req_if.sink                     req_if,
   wcrpm_rsp_if.source                   rsp_if,
   input  logic                          csr_wr_en,
   input  logic [wcrpm_pkg::MODE_W-1:0]  csr_wr_data
);
   import wcrpm_pkg::*;

   seq_state_type   state_ff, state_in;
   seq_ctrl_type    ctrl;
   div_status_type  div_stat;

   logic [MODE_W-1:0] mode_ff;
   logic              have_prev_ff;
   logic [WORD_W-1:0] prev1_ff, prev3_ff, prev5_ff, prev7_ff;
   logic [WORD_W-1:0] dt_a_ff, dr_a_ff, dt_b_ff, dr_b_ff;
   logic              need_a_ff, need_a_in;
   logic              need_b_ff, need_b_in;
   logic              kind_b_ff;
   logic              kind_ff, last_ff;
   logic [NUM_W-1:0]  prod_ff;
   logic [WORD_W-1:0] dsr_ff;
   logic [PAD_W-1:0]  quotient;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff;
   logic [RPM_W-1:0]  rsp_rpm_ff;
   logic              rsp_last_ff;

   logic              accept;
   logic              pick_a;
   logic [WORD_W-1:0] dr_sel;
   logic [PROD_W-1:0] prod_sel;
   logic [WORD_W-1:0] dt_a_cur, dt_b_cur;

   assign accept   = req_if.valid && ctrl.req_ready;
   assign dt_a_cur = req_if.word_at_1 - prev1_ff;
   assign dt_b_cur = req_if.word_at_5 - prev5_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) state_in = ST_SELECT;
         end
         ST_SELECT: begin
            if (need_a_ff || need_b_ff) state_in = ST_START;
            else                        state_in = ST_IDLE;
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_stat.done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_if.ready) state_in = ST_SELECT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE:  ctrl.req_ready = 1'b1;
         ST_START: ctrl.div_start = 1'b1;
         ST_WRITE: ctrl.out_load  = !rsp_valid_ff || rsp_if.ready;
         default:  ctrl = '0;
      endcase
   end

   // measurement pick and rev count scaling
   assign pick_a   = need_a_ff;
   assign dr_sel   = pick_a ? dr_a_ff : dr_b_ff;
   assign prod_sel = PROD_W'(dr_sel) * TICKS_PER_MINUTE;

   always_comb begin
      need_a_in = need_a_ff;
      need_b_in = need_b_ff;
      if (accept) begin
         need_a_in = have_prev_ff && (mode_ff == MODE_COMBINED) && (dt_a_cur != '0);
         need_b_in = have_prev_ff && (dt_b_cur != '0) &&
                     ((mode_ff == MODE_COMBINED) || (mode_ff == MODE_CADENCE) ||
                      (mode_ff == MODE_SPEED));
      end else if (state_ff == ST_SELECT) begin
         if (pick_a) need_a_in = 1'b0;
         else        need_b_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_load)      rsp_valid_in = 1'b1;
      else if (rsp_if.ready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dt_a_ff   <= dt_a_cur;
         dr_a_ff   <= req_if.word_at_3 - prev3_ff;
         dt_b_ff   <= dt_b_cur;
         dr_b_ff   <= req_if.word_at_7 - prev7_ff;
         kind_b_ff <= (mode_ff == MODE_CADENCE) ? KIND_CADENCE : KIND_SPEED;
      end
      if (state_ff == ST_SELECT) begin
         prod_ff <= NUM_W'(prod_sel) << FRACTION_BITS;
         dsr_ff  <= pick_a ? dt_a_ff : dt_b_ff;
         kind_ff <= pick_a ? KIND_CADENCE : kind_b_ff;
         last_ff <= pick_a ? !need_b_ff : 1'b1;
      end
      if (ctrl.out_load) begin
         rsp_kind_ff <= kind_ff;
         rsp_rpm_ff  <= sat_rpm(quotient);
         rsp_last_ff <= last_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_COMBINED;
         have_prev_ff <= 1'b0;
         need_a_ff    <= 1'b0;
         need_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev1_ff     <= '0;
         prev3_ff     <= '0;
         prev5_ff     <= '0;
         prev7_ff     <= '0;
      end else begin
         state_ff     <= (state_ff == ST_IDLE && !accept) ? ST_IDLE : state_in;
         need_a_ff    <= need_a_in;
         need_b_ff    <= need_b_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            prev1_ff     <= req_if.word_at_1;
            prev3_ff     <= req_if.word_at_3;
            prev5_ff     <= req_if.word_at_5;
            prev7_ff     <= req_if.word_at_7;
            have_prev_ff <= 1'b1;
         end
         if (csr_wr_en) mode_ff <= csr_wr_data;
      end
   end

   wcrpm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (prod_ff),
      .divisor  (dsr_ff),
      .quotient (quotient),
      .status   (div_stat)
   );

   assign req_if.ready      = ctrl.req_ready;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.value_kind = rsp_kind_ff;
   assign rsp_if.rpm_fixed  = rsp_rpm_ff;
   assign rsp_if.last       = rsp_last_ff;

   `WCRPM_ASSERT(a_ready_div_idle, clock, reset, ctrl.req_ready |-> !div_stat.busy)
   `WCRPM_ASSERT(a_idle_no_pending, clock, reset, (state_ff == ST_IDLE) |-> !need_a_ff && !need_b_ff)
   `WCRPM_ASSERT(a_load_no_overwrite, clock, reset, ctrl.out_load |-> !rsp_valid_ff || rsp_if.ready)

endmodule
